>>> rtl/blgm_pkg.sv
// Shared types for the line grid marker: coordinates, error term, walk state
// and sequencer states. No dependencies.
`default_nettype none

package blgm_pkg;

	localparam int COORD_W = 6;
	localparam int ERR_W   = 8;

	typedef logic [COORD_W-1:0]      coord_t;
	typedef logic signed [ERR_W-1:0] err_t;

	// Position and Bresenham terms of the line being walked
	typedef struct packed {
		coord_t x;
		coord_t y;
		err_t   err;
		coord_t dx;
		coord_t dy;
		logic   x_dec;
		logic   y_dec;
	} walk_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MARK
	} state_t;

endpackage

`default_nettype wire

>>> rtl/blgm_line_if.sv
// Request channel carrying a pair of line endpoints.
// Depends on blgm_pkg.
`default_nettype none

interface blgm_line_if import blgm_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

`default_nettype wire

>>> rtl/blgm_point_if.sv
// Result channel carrying one line point and its grid flags.
// Depends on blgm_pkg.
`default_nettype none

interface blgm_point_if import blgm_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	logic   in_grid;
	logic   newly_marked;
	logic   last_point;

	modport source (output valid, output point_x, output point_y, output in_grid,
		output newly_marked, output last_point, input ready);
	modport sink (input valid, input point_x, input point_y, input in_grid,
		input newly_marked, input last_point, output ready);
endinterface

`default_nettype wire

>>> rtl/blgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module blgm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 48,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/blgm_step.sv
// Bresenham step unit: advances the walk by one point and flags the end point.
// Depends on blgm_pkg.
`default_nettype none

module blgm_step import blgm_pkg::*; (
	input  walk_t  cur,
	input  coord_t end_x,
	input  coord_t end_y,
	output walk_t  nxt,
	output logic   done
);

	logic signed [ERR_W:0] e2;
	logic signed [ERR_W:0] dx_s;
	logic signed [ERR_W:0] dy_s;
	logic signed [ERR_W:0] err_n;
	logic                  step_x;
	logic                  step_y;

	always_comb begin
		e2     = {cur.err, 1'b0};
		dx_s   = $signed({3'b000, cur.dx});
		dy_s   = $signed({3'b000, cur.dy});
		step_x = e2 > -dy_s;
		step_y = e2 < dx_s;
		err_n  = $signed({cur.err[ERR_W-1], cur.err})
			- (step_x ? dy_s : '0) + (step_y ? dx_s : '0);

		nxt     = cur;
		nxt.err = err_n[ERR_W-1:0];
		if (step_x) begin
			nxt.x = cur.x_dec ? cur.x - 1'b1 : cur.x + 1'b1;
		end
		if (step_y) begin
			nxt.y = cur.y_dec ? cur.y - 1'b1 : cur.y + 1'b1;
		end
		done = (cur.x == end_x) && (cur.y == end_y);
	end

endmodule

`default_nettype wire

>>> rtl/bresenham_line_grid_marker.sv
// Top level of the line grid marker: sequencer, walk registers, result register.
// Depends on blgm_pkg, blgm_line_if, blgm_point_if, blgm_ram, blgm_step.
//
//   channel  dir  payload                                        handshake
//   line     in   start_x, start_y, end_x, end_y                 valid/ready
//   point    out  point_x, point_y, in_grid, newly_marked,       valid/ready
//                 last_point
//
// Each point passes through a read state, which reads the map row, and a mark
// state, which marks it and steps. A request is accepted in the idle state before
// its walk begins; the map row is read before it is modified and written back.
// After reset a clearing pass writes every map row with line.ready low. A stalled
// point channel holds the walk in the mark state; the result register lets the
// next request be taken while the last point waits.
`default_nettype none

module bresenham_line_grid_marker import blgm_pkg::*; #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	blgm_line_if.sink    line,
	blgm_point_if.source point
);

	localparam int AW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam logic [COORD_W:0] COLS_L = (COORD_W+1)'(GRID_COLS);
	localparam logic [COORD_W:0] ROWS_L = (COORD_W+1)'(GRID_ROWS);

	state_t state_q, state_d;

	walk_t  walk_q;
	coord_t end_x_q;
	coord_t end_y_q;
	logic [AW-1:0] clr_cnt_q;

	logic   out_valid_q;
	coord_t out_x_q;
	coord_t out_y_q;
	logic   out_in_grid_q;
	logic   out_marked_q;
	logic   out_last_q;

	walk_t  walk_nxt;
	walk_t  walk_init;
	logic   walk_done;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [GRID_COLS-1:0] ram_wdata;
	logic [GRID_COLS-1:0] ram_rdata;
	logic [AW-1:0]        row_idx;
	logic [CW-1:0]        col_idx;

	logic on_grid;
	logic marked;
	logic emit;

	blgm_step u_step (
		.cur   (walk_q),
		.end_x (end_x_q),
		.end_y (end_y_q),
		.nxt   (walk_nxt),
		.done  (walk_done)
	);

	blgm_ram #(
		.WIDTH (GRID_COLS),
		.DEPTH (GRID_ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (row_idx),
		.rdata (ram_rdata)
	);

	// Set up spans, directions and error term from the request endpoints
	always_comb begin
		walk_init.x     = line.start_x;
		walk_init.y     = line.start_y;
		walk_init.dx    = (line.end_x >= line.start_x) ? line.end_x - line.start_x
			: line.start_x - line.end_x;
		walk_init.dy    = (line.end_y >= line.start_y) ? line.end_y - line.start_y
			: line.start_y - line.end_y;
		walk_init.x_dec = !(line.start_x < line.end_x);
		walk_init.y_dec = !(line.start_y < line.end_y);
		walk_init.err   = $signed({2'b00, walk_init.dx}) - $signed({2'b00, walk_init.dy});
	end

	assign row_idx = walk_q.y[AW-1:0];
	assign col_idx = walk_q.x[CW-1:0];
	assign on_grid = ({1'b0, walk_q.x} < COLS_L) && ({1'b0, walk_q.y} < ROWS_L);
	// The row read in the previous cycle already holds every earlier write
	assign marked  = on_grid && !ram_rdata[col_idx];

	// Sequencer: next state, RAM write and handshake controls
	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = row_idx;
		ram_wdata  = ram_rdata | (GRID_COLS'(1) << col_idx);
		line.ready = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
				if (clr_cnt_q == AW'(GRID_ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				line.ready = 1'b1;
				if (line.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MARK;
			end
			ST_MARK: begin
				// Hold until the result register is free
				if (!out_valid_q || point.ready) begin
					emit    = 1'b1;
					ram_we  = marked;
					state_d = walk_done ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (point.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && line.valid) begin
			walk_q  <= walk_init;
			end_x_q <= line.end_x;
			end_y_q <= line.end_y;
		end else if (emit) begin
			walk_q <= walk_nxt;
		end
		if (emit) begin
			out_x_q       <= walk_q.x;
			out_y_q       <= walk_q.y;
			out_in_grid_q <= on_grid;
			out_marked_q  <= marked;
			out_last_q    <= walk_done;
		end
	end

	assign point.valid        = out_valid_q;
	assign point.point_x      = out_x_q;
	assign point.point_y      = out_y_q;
	assign point.in_grid      = out_in_grid_q;
	assign point.newly_marked = out_marked_q;
	assign point.last_point   = out_last_q;

endmodule

`default_nettype wire

>>> rtl/blgm_checker.sv
// Port-level checks for the line grid marker, bound to the top level.
// Depends on bresenham_line_grid_marker and blgm_pkg.
`default_nettype none

module blgm_checker import blgm_pkg::*; #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 48
) (
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   in_valid,
	input wire logic   in_ready,
	input wire logic   out_valid,
	input wire logic   out_ready,
	input wire coord_t point_x,
	input wire coord_t point_y,
	input wire logic   in_grid,
	input wire logic   newly_marked,
	input wire logic   last_point
);

	localparam logic [COORD_W:0] COLS_L = (COORD_W+1)'(GRID_COLS);
	localparam logic [COORD_W:0] ROWS_L = (COORD_W+1)'(GRID_ROWS);

	// Held point stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("point dropped while stalled");

	// Held point keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(point_x) && $stable(point_y)
			&& $stable(in_grid) && $stable(newly_marked) && $stable(last_point))
		else $error("point payload changed while stalled");

	// A taken request blocks further requests while the line is walked
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while line in progress");

	// Grid flag matches the coordinates; only grid cells get marked
	a_grid_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (in_grid == (({1'b0, point_x} < COLS_L) && ({1'b0, point_y} < ROWS_L)))
			&& (!newly_marked || in_grid))
		else $error("grid flags inconsistent with point");

endmodule

bind bresenham_line_grid_marker blgm_checker #(
	.GRID_COLS (GRID_COLS),
	.GRID_ROWS (GRID_ROWS)
) u_blgm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (line.valid),
	.in_ready     (line.ready),
	.out_valid    (point.valid),
	.out_ready    (point.ready),
	.point_x      (point.point_x),
	.point_y      (point.point_y),
	.in_grid      (point.in_grid),
	.newly_marked (point.newly_marked),
	.last_point   (point.last_point)
);

`default_nettype wire
